>>> src/dmrd_pkg.sv
// -----------------------------------------------------------------------------
// dmrd_pkg
// Shared widths, operation and pulse codes, and the command set that passes
// from the row compare logic to the output stage.
// -----------------------------------------------------------------------------
`default_nettype none

package dmrd_pkg;

   localparam int ROW_W     = 4;
   localparam int PAT_W     = 32;
   localparam int KIND_W    = 2;
   localparam int ROW_SLOTS = 16;   // rows addressable by a 4-bit row index

   // operation codes
   localparam logic OP_DIFF = 1'b0;
   localparam logic OP_FULL = 1'b1;

   // pulse kinds
   localparam logic [KIND_W-1:0] KIND_OFF  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ON   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BOTH = 2'd2;

   // up to two drive commands caused by one item
   typedef struct packed {
      logic              row_ok;        // row in range: store gets updated
      logic [PAT_W-1:0]  store_data;    // masked new row
      logic [ROW_W-1:0]  row;
      logic              first_valid;
      logic [PAT_W-1:0]  first_pat;
      logic [KIND_W-1:0] first_kind;
      logic              first_last;
      logic              second_valid;  // always an on pulse, always last
      logic [PAT_W-1:0]  second_pat;
   } cmd_set_type;

endpackage

`default_nettype wire

>>> src/dmrd_req_if.sv
// -----------------------------------------------------------------------------
// dmrd_req_if
// Request channel: one row update per item.
// -----------------------------------------------------------------------------
`default_nettype none

interface dmrd_req_if;
   import dmrd_pkg::*;

   logic             valid;
   logic             ready;
   logic             operation;
   logic [ROW_W-1:0] row_index;
   logic [PAT_W-1:0] new_row;

   modport source (output valid, output operation, output row_index, output new_row,
                   input ready);
   modport sink   (input valid, input operation, input row_index, input new_row,
                   output ready);
endinterface

`default_nettype wire

>>> src/dmrd_rsp_if.sv
// -----------------------------------------------------------------------------
// dmrd_rsp_if
// Response channel: one drive command per item.
// -----------------------------------------------------------------------------
`default_nettype none

interface dmrd_rsp_if;
   import dmrd_pkg::*;

   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  drive_row;
   logic [PAT_W-1:0]  column_pattern;
   logic [KIND_W-1:0] pulse_kind;
   logic              last;

   modport source (output valid, output drive_row, output column_pattern,
                   output pulse_kind, output last, input ready);
   modport sink   (input valid, input drive_row, input column_pattern,
                   input pulse_kind, input last, output ready);
endinterface

`default_nettype wire

>>> src/dmrd_row_store.sv
// -----------------------------------------------------------------------------
// dmrd_row_store
// Pattern currently shown, one word per row. Cleared by reset.
// -----------------------------------------------------------------------------
`default_nettype none

module dmrd_row_store (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [dmrd_pkg::ROW_W-1:0] rd_addr,
   output logic      [dmrd_pkg::PAT_W-1:0] rd_data,
   input  wire logic                      wr_en,
   input  wire logic [dmrd_pkg::ROW_W-1:0] wr_addr,
   input  wire logic [dmrd_pkg::PAT_W-1:0] wr_data
);
   import dmrd_pkg::*;

   logic [PAT_W-1:0] rows_ff [ROW_SLOTS];

   assign rd_data = rows_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROW_SLOTS; i++) begin
            rows_ff[i] <= '0;
         end
      end else if (wr_en) begin
         rows_ff[wr_addr] <= wr_data;
      end
   end
endmodule

`default_nettype wire

>>> src/dmrd_diff.sv
// -----------------------------------------------------------------------------
// dmrd_diff
// Compares the new row with the shown row and builds the drive commands.
// -----------------------------------------------------------------------------
`default_nettype none

module dmrd_diff #(
   parameter int ROWS = 16,
   parameter int COLS = 32
) (
   input  wire logic                      operation,
   input  wire logic [dmrd_pkg::ROW_W-1:0] row_index,
   input  wire logic [dmrd_pkg::PAT_W-1:0] new_row,
   input  wire logic [dmrd_pkg::PAT_W-1:0] old_row,
   output dmrd_pkg::cmd_set_type          cmds
);
   import dmrd_pkg::*;

   localparam logic [PAT_W-1:0] COL_MASK =
      (COLS >= PAT_W) ? {PAT_W{1'b1}} : PAT_W'((64'd1 << COLS) - 64'd1);
   localparam logic [8:0] ROWS_L = 9'(ROWS);

   logic [PAT_W-1:0] nw;
   logic [PAT_W-1:0] off_bits;
   logic [PAT_W-1:0] on_bits;
   logic             any_off;
   logic             any_on;

   always_comb begin
      nw       = new_row & COL_MASK;
      off_bits = old_row & ~nw & COL_MASK;
      on_bits  = ~old_row & nw & COL_MASK;
      any_off  = |off_bits;
      any_on   = |on_bits;

      cmds              = '0;
      cmds.row          = row_index;
      cmds.store_data   = nw;
      cmds.second_pat   = on_bits;
      cmds.row_ok       = {5'd0, row_index} < ROWS_L;

      if (cmds.row_ok) begin
         if (operation == OP_FULL) begin
            cmds.first_valid = 1'b1;
            cmds.first_pat   = nw;
            cmds.first_kind  = KIND_BOTH;
            cmds.first_last  = 1'b1;
         end else if (any_off) begin
            // off mask is active low
            cmds.first_valid  = 1'b1;
            cmds.first_pat    = ~off_bits;
            cmds.first_kind   = KIND_OFF;
            cmds.first_last   = ~any_on;
            cmds.second_valid = any_on;
         end else if (any_on) begin
            cmds.first_valid = 1'b1;
            cmds.first_pat   = on_bits;
            cmds.first_kind  = KIND_ON;
            cmds.first_last  = 1'b1;
         end
      end
   end
endmodule

`default_nettype wire

>>> src/dmrd_cmd_out.sv
// -----------------------------------------------------------------------------
// dmrd_cmd_out
// Output register plus one pending on-pulse slot for two-command items.
// -----------------------------------------------------------------------------
`default_nettype none

module dmrd_cmd_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire dmrd_pkg::cmd_set_type cmds,
   output logic                      free,
   dmrd_rsp_if.source                rsp_if
);
   import dmrd_pkg::*;

   logic              out_valid_ff, out_valid_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [PAT_W-1:0]  out_pat_ff, out_pat_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic              out_last_ff, out_last_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [PAT_W-1:0]  pend_pat_ff, pend_pat_in;
   logic              fire;

   assign fire = out_valid_ff && rsp_if.ready;
   assign free = !out_valid_ff || (rsp_if.ready && !pend_valid_ff);

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_row_in    = out_row_ff;
      out_pat_in    = out_pat_ff;
      out_kind_in   = out_kind_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_pat_in   = pend_pat_ff;
      if (load) begin
         out_valid_in  = 1'b1;
         out_row_in    = cmds.row;
         out_pat_in    = cmds.first_pat;
         out_kind_in   = cmds.first_kind;
         out_last_in   = cmds.first_last;
         pend_valid_in = cmds.second_valid;
         pend_pat_in   = cmds.second_pat;
      end else if (fire) begin
         if (pend_valid_ff) begin
            out_pat_in    = pend_pat_ff;
            out_kind_in   = KIND_ON;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      out_row_ff  <= out_row_in;
      out_pat_ff  <= out_pat_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
      pend_pat_ff <= pend_pat_in;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.drive_row      = out_row_ff;
   assign rsp_if.column_pattern = out_pat_ff;
   assign rsp_if.pulse_kind     = out_kind_ff;
   assign rsp_if.last           = out_last_ff;
endmodule

`default_nettype wire

>>> src/dot_matrix_row_diff_refresh.sv
// -----------------------------------------------------------------------------
// dot_matrix_row_diff_refresh
// Row refresh for a flip-dot style display: keeps the shown pattern per row
// and turns each row update into off/on drive commands.
// -----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  --------  ---  -------------  ---------------------------------------------
//  req_if    in   valid/ready    operation, row_index, new_row
//  rsp_if    out  valid/ready    drive_row, column_pattern, pulse_kind, last
//
//  An accepted item sits in the input register, where the shown row is read,
//  compared and written back; its commands then load the output register.
//  Full redisplays stream at one item per cycle while rsp_if stays ready; a
//  differential update that both clears and sets pixels holds up the next
//  command-bearing item while the single output register drains its pending
//  on pulse. Synchronous reset clears the shown pattern and all valid flags.
//  A stalled rsp_if holds the output register and then the input register;
//  items with no commands pass through regardless.
// -----------------------------------------------------------------------------
`default_nettype none

module dot_matrix_row_diff_refresh #(
   parameter int ROWS = 16,
   parameter int COLS = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dmrd_req_if.sink   req_if,
   dmrd_rsp_if.source rsp_if
);
   import dmrd_pkg::*;

   // input register
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_op_ff, s1_op_in;
   logic [ROW_W-1:0] s1_row_ff, s1_row_in;
   logic [PAT_W-1:0] s1_new_ff, s1_new_in;

   logic             req_fire;
   logic             s1_advance;
   logic             out_free;
   logic [PAT_W-1:0] old_row;
   cmd_set_type      cmds;

   // an item leaves the input register once its commands have a place to go
   assign s1_advance    = s1_valid_ff && (!cmds.first_valid || out_free);
   assign req_if.ready  = !s1_valid_ff || s1_advance;
   assign req_fire      = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_row_in   = s1_row_ff;
      s1_new_in   = s1_new_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_op_in    = req_if.operation;
         s1_row_in   = req_if.row_index;
         s1_new_in   = req_if.new_row;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_op_ff  <= s1_op_in;
      s1_row_ff <= s1_row_in;
      s1_new_ff <= s1_new_in;
   end

   // read and write back in the same cycle, so the next item sees this update
   dmrd_row_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (s1_row_ff),
      .rd_data (old_row),
      .wr_en   (s1_advance && cmds.row_ok),
      .wr_addr (s1_row_ff),
      .wr_data (cmds.store_data)
   );

   dmrd_diff #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_diff (
      .operation (s1_op_ff),
      .row_index (s1_row_ff),
      .new_row   (s1_new_ff),
      .old_row   (old_row),
      .cmds      (cmds)
   );

   dmrd_cmd_out u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (s1_advance && cmds.first_valid),
      .cmds   (cmds),
      .free   (out_free),
      .rsp_if (rsp_if)
   );
endmodule

`default_nettype wire

>>> bench/tb_dot_matrix_row_diff_refresh.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_dot_matrix_row_diff_refresh
// Self-checking bench for the dot-matrix row refresh block. A scoreboard keeps
// its own copy of the shown rows, predicts the drive commands of every accepted
// row update and checks each accepted command against the oldest prediction.
// Directed corner cases come first, then random updates biased toward the
// current display contents, with random idling on both channels.
// -----------------------------------------------------------------------------

module tb_dot_matrix_row_diff_refresh;
   import dmrd_pkg::*;

   localparam int ROWS        = 16;
   localparam int COLS        = 32;
   localparam int HALF_PERIOD = 10;
   localparam int RAND_ROWS   = 1800;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 10;      // idle tail after the last command, to catch late output
   localparam int IDLE_PCT    = 11;

   // only the low COLS bits of a row are real columns
   localparam bit [PAT_W-1:0] COL_MASK =
      (COLS >= PAT_W) ? {PAT_W{1'b1}} : ((PAT_W'(1) << COLS) - PAT_W'(1));

   typedef struct packed {
      logic [ROW_W-1:0]  drive_row;
      logic [PAT_W-1:0]  column_pattern;
      logic [KIND_W-1:0] pulse_kind;
      logic              last;
   } drive_cmd_type;

   // --------------------------------------------------------------------------
   // Scoreboard: shown-row shadow plus queue of predicted drive commands
   // --------------------------------------------------------------------------
   class row_refresh_board_type;
      bit [PAT_W-1:0] shown [ROWS];
      drive_cmd_type  pending_cmds [$];
      int             mismatches;

      function new();
         foreach (shown[r]) shown[r] = '0;
         mismatches = 0;
      endfunction

      // predict the commands of one accepted row update and advance the shadow
      function void note_update(logic op, logic [ROW_W-1:0] row, logic [PAT_W-1:0] pat);
         bit [PAT_W-1:0] masked;
         bit [PAT_W-1:0] was;
         bit [PAT_W-1:0] going_off;
         bit [PAT_W-1:0] going_on;
         masked = pat & COL_MASK;
         if (row >= ROWS) return;        // out-of-range row: ignored entirely
         was        = shown[row];
         shown[row] = masked;
         if (op == OP_FULL) begin
            pending_cmds.push_back('{row, masked, KIND_BOTH, 1'b1});
            return;
         end
         going_off = was & ~masked & COL_MASK;
         going_on  = ~was & masked & COL_MASK;
         // off mask is active low; columns above COLS stay 1
         if (going_off != '0)
            pending_cmds.push_back('{row, ~going_off, KIND_OFF, going_on == '0});
         if (going_on != '0)
            pending_cmds.push_back('{row, going_on, KIND_ON, 1'b1});
      endfunction

      task report_mismatch(string what);
         $display("[%0t] MISMATCH: %s", $time, what);
         mismatches++;
      endtask

      task check_command(drive_cmd_type got);
         drive_cmd_type want;
         if (pending_cmds.size() == 0) begin
            report_mismatch($sformatf("unexpected command row %0d pattern %h kind %0d",
                                      got.drive_row, got.column_pattern, got.pulse_kind));
            return;
         end
         want = pending_cmds.pop_front();
         if (got.drive_row !== want.drive_row)
            report_mismatch($sformatf("drive_row got %0d want %0d",
                                      got.drive_row, want.drive_row));
         if (got.column_pattern !== want.column_pattern)
            report_mismatch($sformatf("row %0d column_pattern got %h want %h",
                                      want.drive_row, got.column_pattern,
                                      want.column_pattern));
         if (got.pulse_kind !== want.pulse_kind)
            report_mismatch($sformatf("row %0d pulse_kind got %0d want %0d",
                                      want.drive_row, got.pulse_kind, want.pulse_kind));
         if (got.last !== want.last)
            report_mismatch($sformatf("row %0d last got %0b want %0b",
                                      want.drive_row, got.last, want.last));
      endtask

      function int outstanding();
         return pending_cmds.size();
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // Clock, reset, channels, block
   // --------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;
   int   cycles  = 0;
   bit   no_idle = 1'b0;   // set during the stretch where neither side idles

   row_refresh_board_type board = new();

   always #HALF_PERIOD clock = ~clock;

   dmrd_req_if req_if();
   dmrd_rsp_if rsp_if();

   dot_matrix_row_diff_refresh #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // --------------------------------------------------------------------------
   // Watchdog
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Command sink: check every accepted command, stall at random
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            board.check_command('{rsp_if.drive_row, rsp_if.column_pattern,
                                  rsp_if.pulse_kind, rsp_if.last});
         rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // --------------------------------------------------------------------------
   // Row update source
   // --------------------------------------------------------------------------

   // Drive one row update and hold it until accepted. Valid stays high between
   // back-to-back items; an idle gap drops it for one cycle first.
   task automatic send_row(logic op, logic [ROW_W-1:0] row, logic [PAT_W-1:0] pat);
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.row_index <= row;
      req_if.new_row   <= pat;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_update(op, row, pat);
   endtask

   // hold off the source until every predicted command has come back
   task automatic drain_commands();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   // New pattern for a row, mostly derived from what the row shows now so that
   // off-only, on-only, both-way and no-change updates all come up often.
   function automatic logic [PAT_W-1:0] pick_pattern(logic [PAT_W-1:0] cur);
      logic [PAT_W-1:0] r;
      r = $urandom();
      case ($urandom_range(9))
         0, 1:    pick_pattern = r;
         2, 3:    pick_pattern = cur ^ (r & $urandom() & $urandom());  // few flips
         4:       pick_pattern = cur;                                  // no change
         5:       pick_pattern = cur | r;                              // only turn on
         6:       pick_pattern = cur & r;                              // only turn off
         7:       pick_pattern = cur ^ (PAT_W'(1) << $urandom_range(PAT_W - 1));
         8:       pick_pattern = $urandom_range(1) ? '1 : '0;
         default: pick_pattern = ~cur;                                 // every pixel flips
      endcase
   endfunction

   initial begin
      logic [ROW_W-1:0] row;
      logic             op;

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_DIFF;
      req_if.row_index <= '0;
      req_if.new_row   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed corners ----
      send_row(OP_DIFF, 4'd0,  32'h0000_0000);   // no change from reset: silent
      send_row(OP_DIFF, 4'd0,  32'hFFFF_FFFF);   // every pixel on
      send_row(OP_DIFF, 4'd0,  32'h0000_0000);   // every pixel off, mask all zero
      send_row(OP_FULL, 4'd1,  32'hFFFF_FFFF);
      send_row(OP_FULL, 4'd1,  32'h0000_0000);
      send_row(OP_FULL, 4'd1,  32'h0000_0000);   // full redisplay of an unchanged row
      send_row(OP_FULL, 4'd2,  32'hA5A5_A5A5);
      send_row(OP_DIFF, 4'd2,  32'h5A5A_5A5A);   // both directions: off then on
      send_row(OP_DIFF, 4'd2,  32'h5A5A_5A5A);   // identical row: silent
      send_row(OP_DIFF, 4'd15, 32'h8000_0001);
      send_row(OP_DIFF, 4'd15, 32'h0000_0001);   // top column off only
      send_row(OP_DIFF, 4'd15, 32'hFFFF_FFFE);   // both, at the column extremes
      send_row(OP_DIFF, 4'd3,  32'h0000_00FF);
      send_row(OP_DIFF, 4'd3,  32'h0000_FF00);
      send_row(OP_FULL, 4'd3,  32'h0000_0000);
      send_row(OP_DIFF, 4'd14, 32'h0000_0000);   // silent item ahead of a busy one
      send_row(OP_DIFF, 4'd14, 32'h7FFF_FFFF);
      send_row(OP_DIFF, 4'd14, 32'hFFFF_FFFF);
      send_row(OP_FULL, 4'd15, 32'hFFFF_FFFF);
      send_row(OP_DIFF, 4'd15, 32'h0000_0000);
      drain_commands();

      // ---- random updates ----
      row = '0;
      for (int n = 0; n < RAND_ROWS; n++) begin
         no_idle = (n >= 700 && n < 1000);
         if (n % 300 == 299) drain_commands();
         if ($urandom_range(3) != 0) row = ROW_W'($urandom_range(ROWS - 1));  // else reuse
         op = ($urandom_range(3) == 0) ? OP_FULL : OP_DIFF;
         send_row(op, row, pick_pattern(board.shown[row]));
      end
      no_idle = 1'b0;

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
      // trailing silent updates must not produce late commands
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
